// File: rtl/core/mpsm_pkg.sv
// Package for the multi-pattern string matcher: sizes, action and status codes.
package mpsm_pkg;
    localparam int MaxNodes   = 4096;
    localparam int Alphabet   = 26;
    localparam int MaxWordLen = 64;
    localparam int MaxWords   = 1023;
    localparam int MaxResults = 64;

    localparam int NodeW  = $clog2(MaxNodes);
    localparam int CountW = $clog2(MaxNodes + 1);
    localparam int SymW   = 5;
    localparam int IdW    = 10;
    localparam int DepthW = $clog2(MaxWordLen + 1);
    localparam int ResW   = $clog2(MaxResults + 1);
    localparam int GotoDepth = MaxNodes * Alphabet;
    localparam int GotoAw    = $clog2(GotoDepth);

    typedef logic [NodeW-1:0] t_node;
    typedef logic [GotoAw-1:0] t_gaddr;

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_FINISH = 3'd2;
    localparam logic [2:0] ACT_BUILD  = 3'd3;
    localparam logic [2:0] ACT_START  = 3'd4;
    localparam logic [2:0] ACT_SCAN   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;
    localparam logic [1:0] ST_ID   = 2'd3;

    // Row base of a node in the goto memory: node * Alphabet.
    function automatic t_gaddr row_base(input t_node n);
        return t_gaddr'(n) * t_gaddr'(Alphabet);
    endfunction
endpackage

// File: rtl/core/mpsm_ram.sv
// Generic single-port synchronous RAM with registered read.
module mpsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/core/multi_pattern_string_matcher_unit.sv
// Top level of the multi-pattern string matcher (Aho-Corasick automaton).
//
// The input channel carries one item per action: clear, insert symbol, finish
// word, build, start scan, scan symbol. Each item yields one or more result
// items on the output channel; last marks the final one. Items are taken one
// at a time: the input stall stays high until the last result has been
// accepted downstream, and a stalled result holds its value.
// From acceptance to result: start scan, finish, unknown actions and rejected
// inserts answer directly from idle; an insert that follows an existing child
// waits for the goto read, one that allocates a node also for the row sweep.
// A scan symbol reads the goto memory, then walks the failure chain, each
// step one read of the word and link memories. A found word is held
// until the next one or the end of the chain decides its last flag.
// Clear allocates no memory: the root row is rewritten by a row sweep.
// New nodes are initialized by a row sweep on the goto memory.
// Build visits every node breadth-first, 26 symbols per node, with two goto
// reads per symbol and a goto write where the node has no child there.
// After reset the block sweeps the root row before it takes an item. A stall on
// the output simply holds the result; nothing is lost.
module multi_pattern_string_matcher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_action,
    input  logic [4:0]         i_symbol,
    input  logic [9:0]         i_word_id,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic               o_match_found,
    output logic [9:0]         o_matched_id,
    output logic               o_last
);
    import mpsm_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_INS_RD = 5'd2;
    localparam logic [4:0] S_INS_EV = 5'd3;
    localparam logic [4:0] S_ROWCLR = 5'd4;
    localparam logic [4:0] S_SC_RD  = 5'd5;
    localparam logic [4:0] S_SC_EV  = 5'd6;
    localparam logic [4:0] S_CH_EV  = 5'd7;
    localparam logic [4:0] S_OUT    = 5'd8;
    localparam logic [4:0] S_B_RT   = 5'd9;
    localparam logic [4:0] S_B_RTEV = 5'd10;
    localparam logic [4:0] S_B_POP  = 5'd11;
    localparam logic [4:0] S_B_POPW = 5'd12;
    localparam logic [4:0] S_B_FL   = 5'd13;
    localparam logic [4:0] S_B_SYM  = 5'd14;
    localparam logic [4:0] S_B_ALT  = 5'd15;
    localparam logic [4:0] S_B_EV   = 5'd16;
    localparam logic [4:0] S_CH_RD  = 5'd17;
    localparam logic [4:0] S_FIN    = 5'd18;

    logic [4:0]        r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    t_node             r_cursor, n_cursor;
    logic [DepthW-1:0] r_depth, n_depth;
    t_node             r_scan, n_scan;
    logic              r_built, n_built;
    logic [1:0]        r_fault, n_fault;
    logic [4:0]        r_sym, n_sym;
    t_node             r_row, n_row;
    logic [4:0]        r_ci, n_ci;
    logic [4:0]        r_ret, n_ret;
    logic [CountW-1:0] r_head, n_head, r_tail, n_tail;
    t_node             r_u, n_u;
    t_node             r_fu, n_fu;
    t_node             r_v, n_v;
    t_node             r_alt, n_alt;
    logic [ResW-1:0]   r_k, n_k;
    logic [CountW-1:0] r_steps, n_steps;
    logic              r_pv, n_pv;
    logic [IdW-1:0]    r_pid, n_pid;
    logic              r_ov, n_ov;
    logic [1:0]        r_ost, n_ost;
    logic              r_omf, n_omf;
    logic [IdW-1:0]    r_oid, n_oid;
    logic              r_olast, n_olast;

    logic   g_we, f_we, e_we, q_we;
    t_gaddr g_addr;
    t_node  g_wd, g_rd, f_addr, f_wd, f_rd, e_addr, q_rd;
    logic [IdW-1:0] e_wd, e_rd;
    logic [NodeW-1:0] q_addr;
    t_node  q_wd;

    mpsm_ram #(.Width(NodeW), .Depth(GotoDepth)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_addr(g_addr), .i_wdata(g_wd), .o_rdata(g_rd));
    mpsm_ram #(.Width(NodeW), .Depth(MaxNodes)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_addr(f_addr), .i_wdata(f_wd), .o_rdata(f_rd));
    mpsm_ram #(.Width(IdW), .Depth(MaxNodes)) u_word (
        .i_clk(i_clk), .i_we(e_we), .i_addr(e_addr), .i_wdata(e_wd), .o_rdata(e_rd));
    mpsm_ram #(.Width(NodeW), .Depth(MaxNodes)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_addr(q_addr), .i_wdata(q_wd), .o_rdata(q_rd));

    logic accept_in, out_take;
    assign accept_in = i_valid && !o_stall;
    assign out_take  = r_ov && !i_stall;
    assign o_stall   = (r_state != S_IDLE) || r_ov;
    assign o_valid   = r_ov;
    assign o_status  = r_ost;
    assign o_match_found = r_omf;
    assign o_matched_id  = r_oid;
    assign o_last    = r_olast;

    always_comb begin
        n_state = r_state; n_count = r_count; n_cursor = r_cursor; n_depth = r_depth;
        n_scan = r_scan; n_built = r_built; n_fault = r_fault; n_sym = r_sym;
        n_row = r_row; n_ci = r_ci; n_ret = r_ret; n_head = r_head;
        n_tail = r_tail; n_u = r_u; n_fu = r_fu; n_v = r_v; n_alt = r_alt;
        n_k = r_k; n_steps = r_steps; n_pv = r_pv; n_pid = r_pid;
        n_ov = r_ov; n_ost = r_ost; n_omf = r_omf; n_oid = r_oid; n_olast = r_olast;
        g_we = 1'b0; g_addr = '0; g_wd = '0;
        f_we = 1'b0; f_addr = '0; f_wd = '0;
        e_we = 1'b0; e_addr = '0; e_wd = '0;
        q_we = 1'b0; q_addr = '0; q_wd = '0;
        if (out_take) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                n_row = '0; n_ci = '0; n_ret = S_IDLE; n_state = S_ROWCLR;
            end
            S_ROWCLR: begin
                // Sweep one goto row to zero, one symbol per cycle.
                g_we = 1'b1;
                g_addr = row_base(r_row) + t_gaddr'(r_ci);
                if (r_ci == 5'(Alphabet - 1)) begin
                    n_state = r_ret;
                end
                n_ci = r_ci + 5'd1;
            end
            S_FIN: begin
                n_ov = 1'b1; n_omf = 1'b0; n_oid = '0; n_olast = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept_in) begin
                    n_sym = i_symbol; n_ost = ST_OK;
                    n_omf = 1'b0; n_oid = '0; n_olast = 1'b1;
                    case (i_action)
                        ACT_CLEAR: begin
                            n_count = CountW'(1); n_cursor = '0; n_depth = '0;
                            n_scan = '0; n_built = 1'b0; n_fault = '0;
                            n_row = '0; n_ci = '0; n_ret = S_FIN; n_state = S_ROWCLR;
                        end
                        ACT_INSERT: begin
                            if (r_built || i_symbol >= 5'(Alphabet)) begin
                                n_ov = 1'b1;
                            end else if (r_fault != ST_OK) begin
                                n_ost = r_fault; n_ov = 1'b1;
                            end else if (r_depth >= DepthW'(MaxWordLen)) begin
                                n_fault = ST_LONG; n_ost = ST_LONG; n_ov = 1'b1;
                            end else begin
                                g_addr = row_base(r_cursor) + t_gaddr'(i_symbol);
                                n_state = S_INS_EV;
                            end
                        end
                        ACT_FINISH: begin
                            if (!r_built) begin
                                if (r_fault != ST_OK) begin
                                    n_ost = r_fault;
                                end else if (i_word_id == '0 ||
                                             i_word_id > IdW'(MaxWords)) begin
                                    n_ost = ST_ID;
                                end else if (r_cursor != '0) begin
                                    e_we = 1'b1; e_addr = r_cursor; e_wd = i_word_id;
                                end
                                n_cursor = '0; n_depth = '0; n_fault = '0;
                            end
                            n_ov = 1'b1;
                        end
                        ACT_BUILD: begin
                            if (r_built) begin
                                n_ov = 1'b1;
                            end else begin
                                n_ci = '0; n_tail = '0; n_head = '0;
                                g_addr = '0; n_state = S_B_RTEV;
                            end
                        end
                        ACT_START: begin
                            n_scan = '0; n_ov = 1'b1;
                        end
                        ACT_SCAN: begin
                            n_k = '0; n_steps = '0; n_pv = 1'b0;
                            if (i_symbol >= 5'(Alphabet) ||
                                CountW'(r_scan) >= r_count) begin
                                n_scan = '0; n_ov = 1'b1;
                            end else begin
                                g_addr = row_base(r_scan) + t_gaddr'(i_symbol);
                                n_state = S_SC_EV;
                            end
                        end
                        default: begin
                            n_ov = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_EV: begin
                if (g_rd != '0) begin
                    n_cursor = g_rd; n_depth = r_depth + DepthW'(1);
                    n_ov = 1'b1; n_state = S_IDLE;
                end else if (r_count >= CountW'(MaxNodes)) begin
                    n_fault = ST_FULL; n_ost = ST_FULL; n_ov = 1'b1; n_state = S_IDLE;
                end else begin
                    g_we = 1'b1; g_addr = row_base(r_cursor) + t_gaddr'(r_sym);
                    g_wd = t_node'(r_count);
                    f_we = 1'b1; f_addr = t_node'(r_count);
                    e_we = 1'b1; e_addr = t_node'(r_count);
                    n_cursor = t_node'(r_count); n_depth = r_depth + DepthW'(1);
                    n_count = r_count + CountW'(1);
                    n_row = t_node'(r_count); n_ci = '0; n_ret = S_FIN;
                    n_state = S_ROWCLR;
                end
            end
            S_SC_EV: begin
                n_scan = g_rd; n_v = g_rd; n_state = S_CH_RD;
            end
            S_CH_RD: begin
                // Walk one step of the failure chain.
                if (r_v == '0 || CountW'(r_v) >= r_count ||
                    r_steps >= CountW'(MaxNodes) || r_k >= ResW'(MaxResults)) begin
                    n_state = S_OUT;
                end else begin
                    e_addr = r_v; f_addr = r_v; n_state = S_CH_EV;
                end
            end
            S_CH_EV: begin
                if (!r_ov || out_take) begin
                    if (e_rd != '0) begin
                        // A further word proves that the held one is not the final result.
                        if (r_pv) begin
                            n_ov = 1'b1; n_ost = ST_OK; n_omf = 1'b1; n_oid = r_pid;
                            n_olast = 1'b0;
                        end
                        n_pv = 1'b1; n_pid = e_rd; n_k = r_k + ResW'(1);
                    end
                    n_v = f_rd; n_steps = r_steps + CountW'(1);
                    n_state = r_built ? S_CH_RD : S_OUT;
                end else begin
                    e_addr = r_v; f_addr = r_v;
                end
            end
            S_OUT: begin
                // Close the scan: emit the held word as last, or a no-match result.
                if (!r_ov || out_take) begin
                    n_ov = 1'b1; n_ost = ST_OK; n_omf = r_pv;
                    n_oid = r_pv ? r_pid : '0;
                    n_olast = 1'b1; n_pv = 1'b0; n_state = S_IDLE;
                end
            end
            S_B_RT: begin
                g_addr = t_gaddr'(r_ci); n_state = S_B_RTEV;
            end
            S_B_RTEV: begin
                if (g_rd != '0 && r_tail < CountW'(MaxNodes)) begin
                    f_we = 1'b1; f_addr = g_rd;
                    q_we = 1'b1; q_addr = r_tail[NodeW-1:0]; q_wd = g_rd;
                    n_tail = r_tail + CountW'(1);
                end
                n_ci = r_ci + 5'd1;
                n_state = (r_ci == 5'(Alphabet - 1)) ? S_B_POP : S_B_RT;
            end
            S_B_POP: begin
                if (r_head >= r_tail) begin
                    n_built = 1'b1; n_ov = 1'b1; n_state = S_IDLE;
                end else begin
                    q_addr = r_head[NodeW-1:0]; n_head = r_head + CountW'(1);
                    n_state = S_B_POPW;
                end
            end
            S_B_POPW: begin
                n_u = q_rd; f_addr = q_rd; n_ci = '0; n_state = S_B_FL;
            end
            S_B_FL: begin
                n_fu = f_rd; n_state = S_B_SYM;
            end
            S_B_SYM: begin
                g_addr = row_base(r_fu) + t_gaddr'(r_ci); n_state = S_B_ALT;
            end
            S_B_ALT: begin
                n_alt = g_rd; g_addr = row_base(r_u) + t_gaddr'(r_ci);
                n_state = S_B_EV;
            end
            S_B_EV: begin
                if (g_rd == '0) begin
                    g_we = 1'b1; g_addr = row_base(r_u) + t_gaddr'(r_ci); g_wd = r_alt;
                end else if (r_tail < CountW'(MaxNodes)) begin
                    f_we = 1'b1; f_addr = g_rd; f_wd = r_alt;
                    q_we = 1'b1; q_addr = r_tail[NodeW-1:0]; q_wd = g_rd;
                    n_tail = r_tail + CountW'(1);
                end
                n_ci = r_ci + 5'd1;
                n_state = (r_ci == 5'(Alphabet - 1)) ? S_B_POP : S_B_SYM;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_count <= CountW'(1); r_cursor <= '0; r_depth <= '0;
            r_scan <= '0; r_built <= 1'b0; r_fault <= '0; r_ov <= 1'b0;
            r_head <= '0; r_tail <= '0; r_k <= '0; r_steps <= '0;
            r_ci <= '0; r_ret <= S_IDLE; r_row <= '0; r_pv <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_cursor <= n_cursor;
            r_depth <= n_depth; r_scan <= n_scan; r_built <= n_built;
            r_fault <= n_fault; r_ov <= n_ov; r_head <= n_head; r_tail <= n_tail;
            r_k <= n_k; r_steps <= n_steps; r_ci <= n_ci; r_ret <= n_ret; r_row <= n_row;
            r_pv <= n_pv;
        end
        r_sym <= n_sym; r_u <= n_u; r_fu <= n_fu; r_v <= n_v;
        r_alt <= n_alt; r_ost <= n_ost; r_omf <= n_omf; r_oid <= n_oid;
        r_olast <= n_olast; r_pid <= n_pid;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CountW'(1) && r_count <= CountW'(MaxNodes))
        else $error("node count out of range");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input open while busy");
    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_match_found) |-> o_last)
        else $error("non-match result without last");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");
endmodule

// File: tb/tb_multi_pattern_string_matcher_unit.sv
// Self-checking testbench of the Aho-Corasick matcher with a trie and automaton predictor.
module tb_multi_pattern_string_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mpsm_pkg::*;

    // Actions 6 and 7 have no meaning; the block must ignore them.
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam int CycleLimit = 3_000_000;
    localparam int RandItems  = 80;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] symbol;
        logic [9:0] word_id;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic       match_found;
        logic [9:0] matched_id;
        logic       last;
    } t_res;

    typedef struct packed {
        t_cmd       cmd;
        logic       typed;
        logic [1:0] typed_status;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_action = ACT_START;
    logic [4:0] i_symbol = '0;
    logic [9:0] i_word_id = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_status;
    logic       o_match_found;
    logic [9:0] o_matched_id;
    logic       o_last;

    multi_pattern_string_matcher_unit u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted automaton state.
    int unsigned trie_goto[GotoDepth];
    int unsigned trie_fail[MaxNodes];
    int unsigned trie_word[MaxNodes];
    int unsigned bfs_fifo[MaxNodes];
    int unsigned node_cnt, cursor, cur_depth, scan_at, fault;
    bit          is_built;

    t_res pending_results[$];
    int   fail_cnt = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;
    int   stall_hold = 0;
    int   rand_sent = 0;

    task automatic alloc_node(input int unsigned n);
        for (int i = 0; i < Alphabet; i++) trie_goto[n*Alphabet+i] = 0;
        trie_fail[n] = 0;
        trie_word[n] = 0;
    endtask

    task automatic clear_trie();
        node_cnt = 1;
        alloc_node(0);
        cursor = 0;
        cur_depth = 0;
        scan_at = 0;
        is_built = 0;
        fault = 0;
    endtask

    function automatic t_res mk_res(logic [1:0] st, logic mf, logic [9:0] id, logic lst);
        t_res r;
        r.status = st;
        r.match_found = mf;
        r.matched_id = id;
        r.last = lst;
        return r;
    endfunction

    task automatic complete_links();
        int unsigned head, tail, u, v, alt;
        head = 0;
        tail = 0;
        if (is_built) return;
        for (int i = 0; i < Alphabet; i++) begin
            v = trie_goto[i];
            if (v != 0 && tail < MaxNodes) begin
                trie_fail[v] = 0;
                bfs_fifo[tail++] = v;
            end
        end
        while (head < tail) begin
            u = bfs_fifo[head++];
            for (int i = 0; i < Alphabet; i++) begin
                alt = trie_goto[trie_fail[u]*Alphabet+i];
                v = trie_goto[u*Alphabet+i];
                if (v == 0) trie_goto[u*Alphabet+i] = alt;
                else if (tail < MaxNodes) begin
                    trie_fail[v] = alt;
                    bfs_fifo[tail++] = v;
                end
            end
        end
        is_built = 1;
    endtask

    // Advances the predicted automaton by one item and queues its results.
    task automatic automaton_step(input t_cmd c);
        int unsigned st, slot, child, v, steps, k;
        st = ST_OK;
        case (c.action)
            ACT_CLEAR: clear_trie();
            ACT_INSERT: begin
                if (!is_built && c.symbol < Alphabet) begin
                    if (fault != 0) st = fault;
                    else if (cur_depth >= MaxWordLen) begin
                        fault = ST_LONG;
                        st = ST_LONG;
                    end else begin
                        slot = cursor*Alphabet + c.symbol;
                        child = trie_goto[slot];
                        if (child == 0 && node_cnt >= MaxNodes) begin
                            fault = ST_FULL;
                            st = ST_FULL;
                        end else begin
                            if (child == 0) begin
                                child = node_cnt;
                                alloc_node(child);
                                node_cnt++;
                                trie_goto[slot] = child;
                            end
                            cursor = child;
                            cur_depth++;
                        end
                    end
                end
            end
            ACT_FINISH: begin
                if (!is_built) begin
                    if (fault != 0) st = fault;
                    else if (c.word_id == 0 || c.word_id > MaxWords) st = ST_ID;
                    else if (cursor != 0) trie_word[cursor] = c.word_id;
                    cursor = 0;
                    cur_depth = 0;
                    fault = 0;
                end
            end
            ACT_BUILD: complete_links();
            ACT_START: scan_at = 0;
            ACT_SCAN: begin
                if (c.symbol >= Alphabet || scan_at >= node_cnt) scan_at = 0;
                else scan_at = trie_goto[scan_at*Alphabet+c.symbol];
                k = 0;
                steps = 0;
                v = scan_at;
                while (v != 0 && v < node_cnt && steps < MaxNodes && k < MaxResults) begin
                    if (trie_word[v] != 0) begin
                        pending_results.push_back(
                            mk_res(ST_OK, 1'b1, 10'(trie_word[v]), 1'b0));
                        k++;
                    end
                    if (!is_built) break;
                    v = trie_fail[v];
                    steps++;
                end
                if (k == 0) pending_results.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
                else pending_results[$].last = 1'b1;
                return;
            end
            default: ;
        endcase
        pending_results.push_back(mk_res(2'(st), 1'b0, '0, 1'b1));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one item and holds it until the block takes it.
    task automatic send_item(input t_cmd c, input logic typed, input logic [1:0] typed_st);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= c.action;
        i_symbol <= c.symbol;
        i_word_id <= c.word_id;
        if (typed) begin
            // Keep the predictor in step, but check against the hand-written value.
            automaton_step(c);
            pending_results[$] = mk_res(typed_st, 1'b0, '0, 1'b1);
        end else begin
            automaton_step(c);
        end
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_cmd cmd(logic [2:0] a, logic [4:0] s, logic [9:0] id);
        t_cmd c;
        c.action = a;
        c.symbol = s;
        c.word_id = id;
        return c;
    endfunction

    task automatic go(logic [2:0] a, logic [4:0] s, logic [9:0] id);
        send_item(cmd(a, s, id), 1'b0, ST_OK);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [4:0] rand_sym();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 5'($urandom_range(0, 2));
        if (r < 95) return 5'($urandom_range(0, Alphabet - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    t_row dir_rows[] = '{
        '{cmd(ACT_SCAN, 5'd0, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_INSERT, 5'd31, 10'd1023), 1'b1, ST_OK},
        '{cmd(ACT_FINISH, 5'd0, 10'd0), 1'b1, ST_ID},
        '{cmd(ACT_FINISH, 5'd0, 10'd3), 1'b1, ST_OK},
        '{cmd(ACT_INSERT, 5'd0, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_INSERT, 5'd1, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_FINISH, 5'd0, 10'd5), 1'b0, ST_OK},
        '{cmd(ACT_INSERT, 5'd1, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_FINISH, 5'd0, 10'd1023), 1'b0, ST_OK},
        '{cmd(ACT_INSERT, 5'd1, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_FINISH, 5'd31, 10'd7), 1'b0, ST_OK},
        '{cmd(ACT_INSERT, 5'd25, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_FINISH, 5'd0, 10'd1), 1'b0, ST_OK},
        '{cmd(ACT_START, 5'd0, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_SCAN, 5'd0, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_SCAN, 5'd1, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_BUILD, 5'd0, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_BUILD, 5'd0, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_INSERT, 5'd2, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_FINISH, 5'd0, 10'd9), 1'b1, ST_OK},
        '{cmd(ACT_START, 5'd0, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_SCAN, 5'd0, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_SCAN, 5'd1, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_SCAN, 5'd31, 10'd0), 1'b1, ST_OK},
        '{cmd(ACT_SCAN, 5'd25, 10'd0), 1'b0, ST_OK},
        '{cmd(ACT_SPARE6, 5'd31, 10'd1023), 1'b1, ST_OK},
        '{cmd(ACT_SPARE7, 5'd0, 10'd0), 1'b1, ST_OK}
    };

    // Result checker.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d id %0d", o_status, o_matched_id);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_cnt++;
                end
                if (o_match_found !== want.match_found) begin
                    $error("match_found: expected %0d, got %0d", want.match_found, o_match_found);
                    fail_cnt++;
                end
                if (o_matched_id !== want.matched_id) begin
                    $error("matched_id: expected %0d, got %0d", want.matched_id, o_matched_id);
                    fail_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_cnt++;
                end
            end
        end
    end

    // Random back-pressure on the result channel.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (quiet) i_stall <= 1'b0;
        else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            i_stall <= 1'b1;
        end else if (r < 70) i_stall <= 1'b0;
        else if (r < 95) begin
            i_stall <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b1;
            stall_hold <= $urandom_range(10, 40);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int nw, len;
        clear_trie();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].typed_status);
        // Let every result of the directed part come out before going on.
        drain();

        // Over-long word: 64 symbols fit, the next ones do not.
        go(ACT_CLEAR, 5'd0, 10'd0);
        for (int i = 0; i < MaxWordLen; i++) go(ACT_INSERT, 5'd2, 10'd0);
        send_item(cmd(ACT_INSERT, 5'd2, 10'd0), 1'b1, ST_LONG);
        send_item(cmd(ACT_INSERT, 5'd3, 10'd0), 1'b1, ST_LONG);
        send_item(cmd(ACT_FINISH, 5'd0, 10'd4), 1'b1, ST_LONG);

        while (rand_sent < RandItems) begin
            quiet = ($urandom_range(0, 4) == 0);
            go(ACT_CLEAR, 5'd0, 10'd0);
            nw = $urandom_range(1, 6);
            for (int w = 0; w < nw; w++) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) go(ACT_INSERT, rand_sym(), 10'($urandom));
                if ($urandom_range(0, 9) == 0) go(ACT_FINISH, 5'($urandom), 10'd0);
                else go(ACT_FINISH, 5'($urandom), 10'($urandom_range(1, MaxWords)));
                rand_sent += len + 1;
            end
            if ($urandom_range(0, 9) != 0) go(ACT_BUILD, 5'($urandom), 10'($urandom));
            go(ACT_START, 5'($urandom), 10'($urandom));
            len = $urandom_range(10, 25);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0)
                    go(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 10'($urandom));
                else
                    go(ACT_SCAN, rand_sym(), 10'($urandom));
            end
            rand_sent += len + 3;
        end
        quiet = 1'b0;

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
